[rtl/core/ethernet_vlan_header_parser_defines.svh]
// ---------------------------------------------------------------------------
// ethernet vlan header parser assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef ETHERNET_VLAN_HEADER_PARSER_DEFINES_SVH
`define ETHERNET_VLAN_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EVHP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("evhp assertion failed");

// next-cycle implication, disabled during reset
`define EVHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("evhp assertion failed");

`endif

[rtl/core/evhp_pkg.sv]
// ---------------------------------------------------------------------------
// evhp_pkg
// types and constants of the ethernet vlan header parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package evhp_pkg;

  localparam int MAC_W  = 48;
  localparam int WORD_W = 16;
  localparam int VID_W  = 12;
  localparam int PCP_W  = 3;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 5;

  localparam logic [WORD_W-1:0] TPID_CTAG = 16'h8100;
  localparam logic [WORD_W-1:0] TPID_STAG = 16'h88A8;

  // byte offsets within the frame header
  localparam logic [POS_W-1:0] POS_SRC        = 5'd6;
  localparam logic [POS_W-1:0] POS_TYPE       = 5'd12;
  localparam logic [POS_W-1:0] POS_TYPE_LAST  = 5'd13;
  localparam logic [POS_W-1:0] POS_TCI        = 5'd14;
  localparam logic [POS_W-1:0] POS_INNER      = 5'd16;
  localparam logic [POS_W-1:0] POS_INNER_LAST = 5'd17;
  localparam logic [POS_W-1:0] POS_HDR_END    = 5'd18;
  localparam logic [POS_W-1:0] POS_MAX        = 5'd31;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_SHORT   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [MAC_W-1:0]   dest_address;
    logic [MAC_W-1:0]   source_address;
    logic [WORD_W-1:0]  ether_type;
    logic               vlan_present;
    logic [VID_W-1:0]   vlan_ident;
    logic [PCP_W-1:0]   vlan_pcp;
    logic [BYTE_W-1:0]  payload_data;
    logic               end_of_frame;
  } result_t;

endpackage

[rtl/core/evhp_ifs.sv]
// ---------------------------------------------------------------------------
// evhp stream interfaces
// byte input channel and result output channel, valid/ready handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface evhp_in_if import evhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface evhp_out_if import evhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [MAC_W-1:0]  dest_address;
  logic [MAC_W-1:0]  source_address;
  logic [WORD_W-1:0] ether_type;
  logic              vlan_present;
  logic [VID_W-1:0]  vlan_ident;
  logic [PCP_W-1:0]  vlan_pcp;
  logic [BYTE_W-1:0] payload_data;
  logic              end_of_frame;

  modport source (
    output valid, output kind, output dest_address, output source_address,
    output ether_type, output vlan_present, output vlan_ident, output vlan_pcp,
    output payload_data, output end_of_frame, input ready
  );
  modport sink (
    input valid, input kind, input dest_address, input source_address,
    input ether_type, input vlan_present, input vlan_ident, input vlan_pcp,
    input payload_data, input end_of_frame, output ready
  );
endinterface

[rtl/core/evhp_frame_parse.sv]
// ---------------------------------------------------------------------------
// evhp_frame_parse
// per-frame header state and the result caused by the current byte
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module evhp_frame_parse
  import evhp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              frame_end,
  output logic              has_result,
  output result_t           res
);

  logic [POS_W-1:0]  pos, pos_next;
  logic [MAC_W-1:0]  dest_shift, dest_shift_next;
  logic [MAC_W-1:0]  source_shift, source_shift_next;
  logic [WORD_W-1:0] type_word, type_word_next;
  logic              tag_seen, tag_seen_next;
  logic [WORD_W-1:0] tag_control, tag_control_next;
  logic              header_done, header_done_next;
  logic              complete;

  always_comb begin
    pos_next          = (pos != POS_MAX) ? pos + 5'd1 : pos;
    dest_shift_next   = dest_shift;
    source_shift_next = source_shift;
    type_word_next    = type_word;
    tag_seen_next     = tag_seen;
    tag_control_next  = tag_control;
    header_done_next  = header_done;
    complete          = 1'b0;
    res               = '0;
    has_result        = 1'b0;

    if (header_done) begin
      res.kind         = KIND_PAYLOAD;
      res.payload_data = data_byte;
      res.end_of_frame = frame_end;
      has_result       = 1'b1;
    end else begin
      if (pos < POS_SRC) begin
        dest_shift_next = {dest_shift[MAC_W-BYTE_W-1:0], data_byte};
      end else if (pos < POS_TYPE) begin
        source_shift_next = {source_shift[MAC_W-BYTE_W-1:0], data_byte};
      end else if (pos < POS_TCI) begin
        type_word_next = {type_word[WORD_W-BYTE_W-1:0], data_byte};
        if (pos == POS_TYPE_LAST) begin
          if (type_word_next == TPID_CTAG || type_word_next == TPID_STAG) begin
            tag_seen_next = 1'b1;
          end else begin
            complete = 1'b1;
          end
        end
      end else if (pos < POS_INNER) begin
        tag_control_next = {tag_control[WORD_W-BYTE_W-1:0], data_byte};
      end else if (pos < POS_HDR_END) begin
        type_word_next = {type_word[WORD_W-BYTE_W-1:0], data_byte};
        if (pos == POS_INNER_LAST) begin
          complete = 1'b1;
        end
      end

      if (complete) begin
        header_done_next   = 1'b1;
        res.kind           = KIND_HEADER;
        res.dest_address   = dest_shift_next;
        res.source_address = source_shift_next;
        res.ether_type     = type_word_next;
        res.vlan_present   = tag_seen_next;
        if (tag_seen_next) begin
          res.vlan_ident = tag_control_next[VID_W-1:0];
          res.vlan_pcp   = tag_control_next[WORD_W-1:WORD_W-PCP_W];
        end
        res.end_of_frame = frame_end;
        has_result       = 1'b1;
      end else if (frame_end) begin
        res.kind         = KIND_SHORT;
        res.end_of_frame = 1'b1;
        has_result       = 1'b1;
      end
    end

    // frame end returns everything to the start-of-frame state
    if (frame_end) begin
      pos_next          = '0;
      dest_shift_next   = '0;
      source_shift_next = '0;
      type_word_next    = '0;
      tag_seen_next     = 1'b0;
      tag_control_next  = '0;
      header_done_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      dest_shift   <= '0;
      source_shift <= '0;
      type_word    <= '0;
      tag_seen     <= 1'b0;
      tag_control  <= '0;
      header_done  <= 1'b0;
    end else if (accept) begin
      pos          <= pos_next;
      dest_shift   <= dest_shift_next;
      source_shift <= source_shift_next;
      type_word    <= type_word_next;
      tag_seen     <= tag_seen_next;
      tag_control  <= tag_control_next;
      header_done  <= header_done_next;
    end
  end

endmodule

[rtl/core/evhp_out_skid.sv]
// ---------------------------------------------------------------------------
// evhp_out_skid
// result register with a skid stage so one further result is absorbed under stall
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module evhp_out_skid
  import evhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  // a free skid slot means any new beat can be absorbed
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[rtl/core/ethernet_vlan_header_parser.sv]
// ---------------------------------------------------------------------------
// ethernet_vlan_header_parser
// ethernet ii header parser with one 802.1q / 802.1ad tag, byte-wide input
// ---------------------------------------------------------------------------
//
//   channel  dir  beat carries
//   -------  ---  ------------------------------------------------------------
//   frame    in   data_byte, frame_end (one raw frame byte, wire order)
//   result   out  kind, macs, ether_type, vlan fields, payload_data, end_of_frame
//
//   one byte is taken every clock while frame.ready is high; the byte logic
//   is combinational between the frame state registers and the result register
//   frame.ready drops only while the skid stage is full (result stalled
//   with a second result behind it)
//   rst is synchronous and returns the parser to the start of a frame
//
`timescale 1ns / 1ps

module ethernet_vlan_header_parser
  import evhp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  evhp_in_if.sink           frame,
  evhp_out_if.source        result
);

  logic    accept;
  logic    has_result;
  logic    space;
  result_t res;
  result_t out_data;

  // a byte is taken whenever the skid slot is free
  assign frame.ready = space;
  assign accept      = frame.valid && space;

  // header tracking and result formation for the current byte
  evhp_frame_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (frame.data_byte),
    .frame_end  (frame.frame_end),
    .has_result (has_result),
    .res        (res)
  );

  // result register plus skid stage toward the output channel
  evhp_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && has_result),
    .push_data (res),
    .space     (space),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  // unpack the result beat onto the channel
  assign result.kind           = out_data.kind;
  assign result.dest_address   = out_data.dest_address;
  assign result.source_address = out_data.source_address;
  assign result.ether_type     = out_data.ether_type;
  assign result.vlan_present   = out_data.vlan_present;
  assign result.vlan_ident     = out_data.vlan_ident;
  assign result.vlan_pcp       = out_data.vlan_pcp;
  assign result.payload_data   = out_data.payload_data;
  assign result.end_of_frame   = out_data.end_of_frame;

endmodule

[rtl/core/evhp_checker.sv]
// ---------------------------------------------------------------------------
// evhp_checker
// port-level checks on the result channel of the header parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ethernet_vlan_header_parser_defines.svh"

module evhp_checker
  import evhp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              valid,
  input logic              ready,
  input logic [1:0]        kind,
  input logic [MAC_W-1:0]  dest_address,
  input logic [MAC_W-1:0]  source_address,
  input logic [WORD_W-1:0] ether_type,
  input logic              vlan_present,
  input logic [VID_W-1:0]  vlan_ident,
  input logic [PCP_W-1:0]  vlan_pcp,
  input logic [BYTE_W-1:0] payload_data,
  input logic              end_of_frame
);

  // stalled beat stays valid and holds kind, payload_data, end_of_frame and ether_type
  `EVHP_ASSERT_NEXT(a_stall_hold, clk, rst, valid && !ready, valid && $stable(kind) && $stable(payload_data) && $stable(end_of_frame) && $stable(ether_type))

  // short-frame error always closes a frame and carries nothing else
  `EVHP_ASSERT_IMPLIES(a_short_closes, clk, rst, valid && kind == KIND_SHORT, end_of_frame && payload_data == '0 && ether_type == '0)

  // header fields only on header beats
  `EVHP_ASSERT_IMPLIES(a_hdr_fields_zero, clk, rst, valid && kind != KIND_HEADER, dest_address == '0 && source_address == '0 && !vlan_present && vlan_ident == '0 && vlan_pcp == '0)

  // untagged header has empty tag fields, header has no payload byte
  `EVHP_ASSERT_IMPLIES(a_untagged_clean, clk, rst, valid && kind == KIND_HEADER, payload_data == '0 && (vlan_present || (vlan_ident == '0 && vlan_pcp == '0)))

endmodule

bind ethernet_vlan_header_parser evhp_checker u_evhp_checker (
  .clk            (clk),
  .rst            (rst),
  .valid          (result.valid),
  .ready          (result.ready),
  .kind           (result.kind),
  .dest_address   (result.dest_address),
  .source_address (result.source_address),
  .ether_type     (result.ether_type),
  .vlan_present   (result.vlan_present),
  .vlan_ident     (result.vlan_ident),
  .vlan_pcp       (result.vlan_pcp),
  .payload_data   (result.payload_data),
  .end_of_frame   (result.end_of_frame)
);
